// ===== hw/rtl/tkx_pkg.sv =====
// Shared types, opcodes and defaults for the table keystream XOR cipher.
package tkx_pkg;

  localparam int BYTE_W = 8;
  localparam int DEF_TABLE_SIZE = 256;

  typedef logic [1:0] opcode_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam opcode_t OP_KEY_WR = 2'd0;
  localparam opcode_t OP_START  = 2'd1;
  localparam opcode_t OP_DATA   = 2'd2;
  localparam opcode_t OP_NOP    = 2'd3;

endpackage

// ===== hw/rtl/tkx_ram.sv =====
// Simple dual-port synchronous RAM with registered read, write-first on address match.
module tkx_ram #(
  parameter int DEPTH = tkx_pkg::DEF_TABLE_SIZE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tkx_pkg::byte_t   wdata,
  input  logic [AW-1:0]    raddr,
  output tkx_pkg::byte_t   rdata
);
  import tkx_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tkx_addmod.sv =====
// Index adder: (a mod TABLE_SIZE + b mod TABLE_SIZE) mod TABLE_SIZE for byte operands.
module tkx_addmod #(
  parameter int TABLE_SIZE = tkx_pkg::DEF_TABLE_SIZE,
  parameter int IW         = $clog2(TABLE_SIZE)
) (
  input  tkx_pkg::byte_t  a,
  input  tkx_pkg::byte_t  b,
  output logic [IW-1:0]   sum
);
  import tkx_pkg::*;

  localparam int LUT_N = 1 << BYTE_W;
  localparam logic [IW:0] TS_W = (IW+1)'(TABLE_SIZE);

  logic [IW-1:0] mod_lut [LUT_N];
  logic [IW-1:0] ra;
  logic [IW-1:0] rb;
  logic [IW:0]   s;

  for (genvar g = 0; g < LUT_N; g++) begin : g_lut
    assign mod_lut[g] = IW'(g % TABLE_SIZE);
  end

  assign ra  = mod_lut[a];
  assign rb  = mod_lut[b];
  assign s   = {1'b0, ra} + {1'b0, rb};
  assign sum = (s >= TS_W) ? IW'(s - TS_W) : s[IW-1:0];

endmodule

// ===== hw/rtl/table_keystream_xor_cipher_unit.sv =====
// Top level: table-loaded RC4-style keystream XOR cipher with key and work table RAMs.
//
//  channel | direction | ports                                           | handshake
//  in_     | request   | in_opcode, in_entry_index, in_entry_value,      | in_valid / in_stall
//          |           | in_data_in                                      |
//  out_    | result    | out_data_out                                    | out_valid / out_stall
//
// Data byte: requests run back to back; the work RAM's single read port serves
//   the three dependent reads (state[x], state[y], state[sel]) one per cycle.
// Start message: sweeps the key RAM into the work RAM.
// Key write and unused opcode return to idle. Reset clears control state and indices; tables are not cleared.
// A stalled output holds a finished byte in the last stage, and no new request is taken there.
module table_keystream_xor_cipher_unit #(
  parameter int TABLE_SIZE = tkx_pkg::DEF_TABLE_SIZE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tkx_pkg::opcode_t in_opcode,
  input  tkx_pkg::byte_t   in_entry_index,
  input  tkx_pkg::byte_t   in_entry_value,
  input  tkx_pkg::byte_t   in_data_in,
  output logic             out_valid,
  input  logic             out_stall,
  output tkx_pkg::byte_t   out_data_out
);
  import tkx_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [CW-1:0]     CNT_END = CW'(TABLE_SIZE);
  localparam logic [IW-1:0]     X_LAST  = IW'(TABLE_SIZE - 1);
  localparam logic [BYTE_W:0]   TS_CMP  = (BYTE_W+1)'(TABLE_SIZE);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COPY = 3'd1;
  localparam logic [2:0] ST_RDY  = 3'd2;
  localparam logic [2:0] ST_SWP  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] x_r, x_nxt;
  logic [IW-1:0] y_r, y_nxt;
  logic [IW-1:0] sel_r, sel_nxt;
  byte_t         sx_r, sx_nxt;
  byte_t         din_r, din_nxt;
  logic          out_valid_r, out_valid_nxt;
  byte_t         out_data_r, out_data_nxt;

  logic          out_free;
  logic          in_acc;
  logic [IW-1:0] x_inc;
  logic [IW-1:0] y_sum;
  logic [IW-1:0] sel_sum;
  byte_t         keystream;

  logic          key_we;
  byte_t         key_rdata;
  logic          work_we;
  logic [IW-1:0] work_waddr;
  byte_t         work_wdata;
  logic [IW-1:0] work_raddr;
  byte_t         work_rdata;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));
  assign in_acc   = in_valid && !in_stall;
  assign x_inc    = (x_r == X_LAST) ? '0 : x_r + 1'b1;
  assign key_we   = in_acc && (in_opcode == OP_KEY_WR) &&
                    ({1'b0, in_entry_index} < TS_CMP);
  assign keystream = (sel_r == y_r) ? sx_r : work_rdata;

  tkx_addmod #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_ymix (
    .a   (BYTE_W'(y_r)),
    .b   (work_rdata),
    .sum (y_sum)
  );

  tkx_addmod #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_sel (
    .a   (sx_r),
    .b   (work_rdata),
    .sum (sel_sum)
  );

  tkx_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_entry_index[IW-1:0]),
    .wdata (in_entry_value),
    .raddr (cnt_r[IW-1:0]),
    .rdata (key_rdata)
  );

  tkx_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (work_raddr),
    .rdata (work_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sel_nxt       = sel_r;
    sx_nxt        = sx_r;
    din_nxt       = din_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    work_we       = 1'b0;
    work_waddr    = x_r;
    work_wdata    = work_rdata;
    work_raddr    = x_inc;

    unique case (state_r)
      ST_COPY: begin
        cnt_nxt    = cnt_r + 1'b1;
        work_we    = (cnt_r != '0);
        work_waddr = IW'(cnt_r - 1'b1);
        work_wdata = key_rdata;
        if (cnt_r == CNT_END) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDY: begin
        sx_nxt     = work_rdata;
        y_nxt      = y_sum;
        work_raddr = y_sum;
        state_nxt  = ST_SWP;
      end
      ST_SWP: begin
        work_we    = 1'b1;
        work_waddr = x_r;
        work_wdata = work_rdata;
        sel_nxt    = sel_sum;
        work_raddr = sel_sum;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        work_we    = 1'b1;
        work_waddr = y_r;
        work_wdata = sx_r;
        work_raddr = sel_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = din_r ^ keystream;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (in_acc) begin
      unique case (in_opcode) inside
        OP_START: begin
          state_nxt = ST_COPY;
          cnt_nxt   = '0;
          x_nxt     = '0;
          y_nxt     = '0;
        end
        OP_DATA: begin
          state_nxt  = ST_RDY;
          x_nxt      = x_inc;
          din_nxt    = in_data_in;
          work_raddr = x_inc;
        end
        OP_KEY_WR, OP_NOP: begin
          state_nxt = ST_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    sx_r       <= sx_nxt;
    din_r      <= din_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  a_data_three_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_DATA)) |-> ##3 (state_r == ST_FIN))
    else $error("data request did not reach final stage in three cycles");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && out_valid_r && out_stall) |-> in_stall)
    else $error("request taken while finished byte is blocked");

  a_key_write_outside_copy: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (state_r != ST_COPY))
    else $error("key table written during copy sweep");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && out_free) |=> out_valid_r)
    else $error("final stage did not load output register");

endmodule

// ===== tb/table_keystream_xor_cipher_checker.sv =====
// Checker: predicts keystream cipher results from accepted requests and compares them.
`timescale 1ns / 100ps

module table_keystream_xor_cipher_checker #(
  parameter int TABLE_SIZE = tkx_pkg::DEF_TABLE_SIZE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  tkx_pkg::opcode_t in_opcode,
  input  tkx_pkg::byte_t   in_entry_index,
  input  tkx_pkg::byte_t   in_entry_value,
  input  tkx_pkg::byte_t   in_data_in,
  input  logic             out_valid,
  input  logic             out_stall,
  input  tkx_pkg::byte_t   out_data_out,
  output int               fail_count,
  output int               pending_count
);
  import tkx_pkg::*;

  byte_t key_tbl [TABLE_SIZE];
  byte_t work_tbl [TABLE_SIZE];
  int    step_ptr;
  int    mix_ptr;
  byte_t expected_bytes [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
    step_ptr = 0;
    mix_ptr = 0;
  end

  always @(posedge clk) begin : track
    byte_t sx;
    byte_t sy;
    byte_t ks;
    byte_t exp_byte;
    if (!rst_n) begin
      step_ptr = 0;
      mix_ptr = 0;
      expected_bytes.delete();
    end else begin
      // results first: a result can never stem from the request taken at the same edge
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected data_out, expected none, actual %02h", $time, out_data_out);
          fail_count <= fail_count + 1;
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (out_data_out !== exp_byte) begin
            $display("%0t: data_out mismatch, expected %02h, actual %02h",
                     $time, exp_byte, out_data_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_KEY_WR: begin
            if (int'(in_entry_index) < TABLE_SIZE) key_tbl[in_entry_index] = in_entry_value;
          end
          OP_START: begin
            work_tbl = key_tbl;
            step_ptr = 0;
            mix_ptr = 0;
          end
          OP_DATA: begin
            step_ptr = (step_ptr + 1) % TABLE_SIZE;
            mix_ptr = (mix_ptr + int'(work_tbl[step_ptr])) % TABLE_SIZE;
            sx = work_tbl[step_ptr];
            sy = work_tbl[mix_ptr];
            work_tbl[step_ptr] = sy;
            work_tbl[mix_ptr] = sx;
            ks = work_tbl[(int'(sx) + int'(sy)) % TABLE_SIZE];
            expected_bytes.push_back(in_data_in ^ ks);
          end
          default: ;
        endcase
      end
    end
    pending_count <= expected_bytes.size();
  end

endmodule

// ===== tb/table_keystream_xor_cipher_unit_tb.sv =====
// Testbench top: request stimulus, result-side stalls, watchdog and verdict for the cipher unit.
`timescale 1ns / 100ps

module table_keystream_xor_cipher_unit_tb;
  import tkx_pkg::*;

  localparam int TABLE_SIZE     = DEF_TABLE_SIZE;
  localparam int ITEM_TARGET    = 1600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 300;

  typedef enum {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_LONG} stall_mode_t;
  typedef enum {KEY_RANDOM, KEY_IDENTITY, KEY_FLAT} key_pattern_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  opcode_t in_opcode = OP_NOP;
  byte_t   in_entry_index = '0;
  byte_t   in_entry_value = '0;
  byte_t   in_data_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  byte_t   out_data_out;

  int fail_count;
  int pending_count;
  int sent_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_phase = 0;

  always #5 clk = ~clk;

  table_keystream_xor_cipher_unit #(.TABLE_SIZE(TABLE_SIZE)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out)
  );

  table_keystream_xor_cipher_checker #(.TABLE_SIZE(TABLE_SIZE)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // result-side stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
      default:      out_stall <= ((stall_phase % 24) < 16);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_request(input opcode_t op, input byte_t idx, input byte_t val,
                              input byte_t din);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_data_in <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_NOP) sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic load_key_table(input key_pattern_t pattern);
    byte_t val;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      case (pattern)
        KEY_IDENTITY: val = byte_t'(i);
        KEY_FLAT:     val = 8'hFF;
        default:      val = byte_t'($urandom);
      endcase
      send_request(OP_KEY_WR, byte_t'(i), val, byte_t'($urandom));
    end
  endtask

  task automatic send_data(input byte_t din);
    send_request(OP_DATA, byte_t'($urandom), byte_t'($urandom), din);
  endtask

  task automatic send_start();
    send_request(OP_START, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
  endtask

  initial begin
    int msg_len;
    int pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every key entry is written before the first message start
    load_key_table(KEY_RANDOM);

    // directed part
    send_start();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'h5A);
    send_request(OP_NOP, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_NOP, 8'h00, 8'h00, 8'h00);
    // key writes mid-message leave the running work table alone
    send_request(OP_KEY_WR, 8'h00, 8'hFF, 8'h00);
    send_request(OP_KEY_WR, 8'hFF, 8'h00, 8'hFF);
    send_request(OP_KEY_WR, 8'h01, 8'h01, 8'h33);
    send_data(8'h00);
    send_data(8'hFF);
    send_start();
    send_data(8'h00);
    send_data(8'hFF);
    send_start();
    send_start();
    send_data(8'h80);
    send_data(8'h01);
    wait_drained();

    // random part: mostly full messages, some noise and key updates mid-message
    while (sent_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        load_key_table(key_pattern_t'($urandom_range(0, 2)));
      end else begin
        repeat ($urandom_range(0, 6))
          send_request(OP_KEY_WR, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
      end
      send_start();
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(260, 320) : $urandom_range(1, 40);
      for (int j = 0; j < msg_len; j++) begin
        pick = $urandom_range(0, 31);
        if (pick == 0)
          send_request(OP_NOP, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
        else if (pick == 1)
          send_request(OP_KEY_WR, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
        else
          send_data(byte_t'($urandom));
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tkx_pkg.sv
hw/rtl/tkx_ram.sv
hw/rtl/tkx_addmod.sv
hw/rtl/table_keystream_xor_cipher_unit.sv
tb/table_keystream_xor_cipher_checker.sv
tb/table_keystream_xor_cipher_unit_tb.sv
